>>> rtl/core/amfs_pkg.sv
// ----------------------------------------------------------------------------
// amfs_pkg
// Shared types, constants and codes of the alarm and message flag scanner.
// ----------------------------------------------------------------------------
package amfs_pkg;

  localparam int unsigned ALARM_WORDS_DEF      = 16;
  localparam int unsigned MSG_WORDS_DEF        = 16;
  localparam int unsigned ALARM_LIST_DEPTH_DEF = 10;
  localparam int unsigned MSG_LIST_DEPTH_DEF   = 4;
  localparam int unsigned REPORT_DEPTH_DEF     = 16;
  localparam int unsigned NUM_COUNTERS         = 256;
  localparam int unsigned CFG_IDX_W            = 2;
  localparam int unsigned CFG_DATA_W           = 16;

  typedef enum logic [1:0] {
    REQ_ALARM = 2'd0,
    REQ_MSG   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SEL_ALARM  = 2'd0,
    SEL_MSG    = 2'd1,
    SEL_REPORT = 2'd2,
    SEL_NONE   = 2'd3
  } sel_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MSG_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_BASE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_BIT,
    ST_CNT,
    ST_EMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        req_valid;
    logic        bits_done;
    logic        cur_bit;
    logic        cnt_over;
    logic        report_busy;
    logic        out_busy;
    logic        any_emitted;
    logic        word_in_range;
    req_t        req_type;
    logic        flags_zero;
  } amfs_sts_t;

  typedef struct packed {
    logic load;
    logic do_clears;
    logic next_bit;
    logic cnt_read;
    logic alarm_op;
    logic msg_hit;
    logic emit_event;
    logic emit_empty;
    logic zero_word;
  } amfs_cmd_t;

  typedef struct packed {
    logic        event_valid;
    logic        event_kind;
    logic [15:0] event_code;
    logic [7:0]  read_data;
    logic        alarms_active;
    logic        messages_active;
    logic        last;
  } amfs_out_t;

endpackage

>>> rtl/core/amfs_if.sv
// ----------------------------------------------------------------------------
// amfs_in_if / amfs_out_if
// Valid-ready channels of the scanner.
// ----------------------------------------------------------------------------
interface amfs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  word_index;
  logic [15:0] flag_bits;
  logic        scan_start;
  logic        clear_report_list;
  logic [1:0]  list_select;
  logic [3:0]  entry_index;
  modport source (output valid, req_type, word_index, flag_bits, scan_start,
                  clear_report_list, list_select, entry_index, input ready);
  modport sink (input valid, req_type, word_index, flag_bits, scan_start,
                clear_report_list, list_select, entry_index, output ready);
endinterface

interface amfs_out_if;
  logic        valid;
  logic        ready;
  logic        event_valid;
  logic        event_kind;
  logic [15:0] event_code;
  logic [7:0]  read_data;
  logic        alarms_active;
  logic        messages_active;
  logic        last;
  modport source (output valid, event_valid, event_kind, event_code, read_data,
                  alarms_active, messages_active, last, input ready);
  modport sink (input valid, event_valid, event_kind, event_code, read_data,
                alarms_active, messages_active, last, output ready);
endinterface

>>> rtl/core/alarm_message_flag_scanner.sv
// a read, a type 3 item or a zero message word goes from the clear state straight
//   to the emit state and its one result; alarm and message words walk 16 bits in
//   order: a clear bit is skipped, a message bit reads its counter and then counts
//   up or reports, an alarm bit starts a 16-slot report sweep; one item at a time,
//   taken after the last result beat and held off by a sweep or zero-word clear
// reset: synchronous active-low; the 256 counters are then zeroed, no item taken
// ----------------------------------------------------------------------------
// alarm_message_flag_scanner
// Scans alarm and message flag words into display and report lists.
// ----------------------------------------------------------------------------
module alarm_message_flag_scanner #(
  parameter int unsigned ALARM_WORDS      = amfs_pkg::ALARM_WORDS_DEF,
  parameter int unsigned MSG_WORDS        = amfs_pkg::MSG_WORDS_DEF,
  parameter int unsigned ALARM_LIST_DEPTH = amfs_pkg::ALARM_LIST_DEPTH_DEF,
  parameter int unsigned MSG_LIST_DEPTH   = amfs_pkg::MSG_LIST_DEPTH_DEF,
  parameter int unsigned REPORT_DEPTH     = amfs_pkg::REPORT_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  amfs_in_if.sink    in_ch,
  amfs_out_if.source out_ch,
  input  logic                            cfg_wr_en,
  input  logic [amfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  amfs_pkg::amfs_cmd_t cmd;
  amfs_pkg::amfs_sts_t sts;
  amfs_pkg::amfs_out_t od;
  logic                rdy;

  amfs_ctrl u_ctrl (.clk, .rst_n, .sts, .cmd, .in_ready(rdy));

  amfs_dpath #(
    .ALARM_WORDS(ALARM_WORDS), .MSG_WORDS(MSG_WORDS),
    .ALARM_LIST_DEPTH(ALARM_LIST_DEPTH), .MSG_LIST_DEPTH(MSG_LIST_DEPTH),
    .REPORT_DEPTH(REPORT_DEPTH)
  ) u_dpath (
    .clk, .rst_n, .cmd, .sts,
    .in_valid(in_ch.valid), .in_req_type(in_ch.req_type),
    .in_word_index(in_ch.word_index), .in_flag_bits(in_ch.flag_bits),
    .in_scan_start(in_ch.scan_start),
    .in_clear_report_list(in_ch.clear_report_list),
    .in_list_select(in_ch.list_select), .in_entry_index(in_ch.entry_index),
    .cfg_wr_en, .cfg_index, .cfg_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(od)
  );

  assign in_ch.ready = rdy && sts.req_valid;

  assign out_ch.event_valid     = od.event_valid;
  assign out_ch.event_kind      = od.event_kind;
  assign out_ch.event_code      = od.event_code;
  assign out_ch.read_data       = od.read_data;
  assign out_ch.alarms_active   = od.alarms_active;
  assign out_ch.messages_active = od.messages_active;
  assign out_ch.last            = od.last;

endmodule

>>> rtl/core/amfs_ctrl.sv
// ----------------------------------------------------------------------------
// amfs_ctrl
// Sequencer: takes each item, walks the 16 flag bits of an alarm or nonzero message word in order.
// ----------------------------------------------------------------------------
module amfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  amfs_pkg::amfs_sts_t sts,
  output amfs_pkg::amfs_cmd_t cmd,
  output logic                in_ready
);

  amfs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= amfs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      amfs_pkg::ST_IDLE: begin
        if (sts.req_valid) state_nxt = amfs_pkg::ST_CLEAR;
      end
      amfs_pkg::ST_CLEAR: begin
        if (sts.word_in_range && sts.req_type == amfs_pkg::REQ_ALARM)
          state_nxt = amfs_pkg::ST_BIT;
        else if (sts.word_in_range && sts.req_type == amfs_pkg::REQ_MSG &&
                 !sts.flags_zero)
          state_nxt = amfs_pkg::ST_BIT;
        else
          state_nxt = amfs_pkg::ST_EMIT;
      end
      amfs_pkg::ST_BIT: begin
        if (sts.bits_done) begin
          state_nxt = amfs_pkg::ST_EMIT;
        end else if (sts.cur_bit && !sts.out_busy) begin
          if (sts.req_type == amfs_pkg::REQ_MSG) state_nxt = amfs_pkg::ST_CNT;
          else if (!sts.report_busy) state_nxt = amfs_pkg::ST_BIT;
        end
      end
      amfs_pkg::ST_CNT: begin
        if (!sts.out_busy) state_nxt = amfs_pkg::ST_BIT;
      end
      amfs_pkg::ST_EMIT: begin
        if (!sts.out_busy) state_nxt = amfs_pkg::ST_OUT;
      end
      amfs_pkg::ST_OUT: begin
        if (!sts.out_busy && !sts.report_busy) state_nxt = amfs_pkg::ST_IDLE;
      end
      default: state_nxt = amfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      amfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = sts.req_valid;
      end
      amfs_pkg::ST_CLEAR: begin
        cmd.do_clears = 1'b1;
        cmd.zero_word = sts.word_in_range && sts.req_type == amfs_pkg::REQ_MSG &&
                        sts.flags_zero;
      end
      amfs_pkg::ST_BIT: begin
        if (!sts.bits_done) begin
          if (!sts.cur_bit) begin
            cmd.next_bit = 1'b1;
          end else if (!sts.out_busy) begin
            if (sts.req_type == amfs_pkg::REQ_MSG) begin
              cmd.cnt_read = 1'b1;
            end else if (!sts.report_busy) begin
              cmd.alarm_op   = 1'b1;
              cmd.emit_event = 1'b1;
              cmd.next_bit   = 1'b1;
            end
          end
        end
      end
      amfs_pkg::ST_CNT: begin
        if (!sts.out_busy) begin
          cmd.msg_hit    = 1'b1;
          cmd.emit_event = sts.cnt_over;
          cmd.next_bit   = 1'b1;
        end
      end
      amfs_pkg::ST_EMIT: begin
        // close the item: mark last, or send one empty result
        cmd.emit_empty = !sts.out_busy;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/amfs_dpath.sv
// ----------------------------------------------------------------------------
// amfs_dpath
// Lists, counter memory, report search and the output stage.
// ----------------------------------------------------------------------------
module amfs_dpath #(
  parameter int unsigned ALARM_WORDS      = amfs_pkg::ALARM_WORDS_DEF,
  parameter int unsigned MSG_WORDS        = amfs_pkg::MSG_WORDS_DEF,
  parameter int unsigned ALARM_LIST_DEPTH = amfs_pkg::ALARM_LIST_DEPTH_DEF,
  parameter int unsigned MSG_LIST_DEPTH   = amfs_pkg::MSG_LIST_DEPTH_DEF,
  parameter int unsigned REPORT_DEPTH     = amfs_pkg::REPORT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  amfs_pkg::amfs_cmd_t cmd,
  output amfs_pkg::amfs_sts_t sts,
  input  logic                in_valid,
  input  logic [1:0]          in_req_type,
  input  logic [3:0]          in_word_index,
  input  logic [15:0]         in_flag_bits,
  input  logic                in_scan_start,
  input  logic                in_clear_report_list,
  input  logic [1:0]          in_list_select,
  input  logic [3:0]          in_entry_index,
  input  logic                cfg_wr_en,
  input  logic [amfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amfs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output amfs_pkg::amfs_out_t out_data
);

  localparam int unsigned CNT_W = $clog2(amfs_pkg::NUM_COUNTERS);
  localparam int unsigned AL_W  = (ALARM_LIST_DEPTH > 1) ? $clog2(ALARM_LIST_DEPTH) : 1;
  localparam int unsigned ML_W  = (MSG_LIST_DEPTH > 1) ? $clog2(MSG_LIST_DEPTH) : 1;

  // configuration
  logic [15:0] msg_delay_r, alarm_base_r, msg_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_delay_r  <= '0;
      alarm_base_r <= '0;
      msg_base_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        amfs_pkg::CFG_MSG_DELAY:  msg_delay_r  <= cfg_data;
        amfs_pkg::CFG_ALARM_BASE: alarm_base_r <= cfg_data;
        amfs_pkg::CFG_MSG_BASE:   msg_base_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured item
  logic [1:0]  req_r;
  logic [3:0]  word_r;
  logic [15:0] flags_r;
  logic        start_r, clr_rep_r;
  logic [1:0]  sel_r;
  logic [3:0]  ent_r;
  logic [4:0]  bit_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= in_req_type;
      word_r    <= in_word_index;
      flags_r   <= in_flag_bits;
      start_r   <= in_scan_start;
      clr_rep_r <= in_clear_report_list;
      sel_r     <= in_list_select;
      ent_r     <= in_entry_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (cmd.load) begin
      bit_r <= '0;
    end else if (cmd.next_bit) begin
      bit_r <= bit_r + 5'd1;
    end
  end

  logic [3:0] bit4;
  logic [7:0] idx;
  assign bit4 = bit_r[3:0];
  assign idx  = {word_r, bit4};

  // persistence counters, one read and one write port
  logic [15:0] cnt_mem [amfs_pkg::NUM_COUNTERS];
  logic [15:0] cnt_rd_r;
  logic [3:0]  zclr_r;
  logic        zbusy_r;
  logic        cnt_over;
  assign cnt_over = cnt_rd_r > msg_delay_r;

  // after reset the counters are swept to zero
  logic [CNT_W:0] init_r;
  logic           init_busy;
  assign init_busy = !init_r[CNT_W];

  // display lists and seen flags
  logic [7:0] alist_r [ALARM_LIST_DEPTH];
  logic [7:0] mlist_r [MSG_LIST_DEPTH];
  logic       aseen_r, mseen_r;
  logic       clr_disp;
  assign clr_disp = cmd.do_clears && start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALARM_LIST_DEPTH; i++) alist_r[i] <= '0;
      for (int i = 0; i < MSG_LIST_DEPTH; i++) mlist_r[i] <= '0;
      aseen_r <= 1'b0;
      mseen_r <= 1'b0;
    end else if (clr_disp) begin
      for (int i = 0; i < ALARM_LIST_DEPTH; i++) alist_r[i] <= '0;
      for (int i = 0; i < MSG_LIST_DEPTH; i++) mlist_r[i] <= '0;
      aseen_r <= 1'b0;
      mseen_r <= 1'b0;
    end else begin
      if (cmd.alarm_op) begin
        for (int i = ALARM_LIST_DEPTH - 1; i > 0; i--) alist_r[i] <= alist_r[i-1];
        alist_r[0] <= idx;
        aseen_r    <= 1'b1;
      end
      if (cmd.msg_hit) begin
        mseen_r <= 1'b1;
        if (cnt_over) begin
          for (int i = MSG_LIST_DEPTH - 1; i > 0; i--) mlist_r[i] <= mlist_r[i-1];
          mlist_r[0] <= idx;
        end
      end
    end
  end

  // report list: search and insert walk the slots one per cycle
  localparam int unsigned RP_W = (REPORT_DEPTH > 1) ? $clog2(REPORT_DEPTH) : 1;
  logic [7:0]  rep_r [REPORT_DEPTH];
  logic        rbusy_r, rfound_r, rfree_ok_r;
  logic [RP_W:0]   rpos_r;
  logic [RP_W-1:0] rfree_r;
  logic [7:0]  rcode_r;
  logic [7:0]  rcur;
  assign rcur = rep_r[rpos_r[RP_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REPORT_DEPTH; i++) rep_r[i] <= '0;
      rbusy_r <= 1'b0;
    end else if (cmd.do_clears && clr_rep_r) begin
      for (int i = 0; i < REPORT_DEPTH; i++) rep_r[i] <= '0;
    end else if (cmd.alarm_op) begin
      rbusy_r    <= 1'b1;
      rpos_r     <= '0;
      rcode_r    <= idx;
      rfound_r   <= 1'b0;
      rfree_ok_r <= 1'b0;
    end else if (rbusy_r) begin
      if (rpos_r == (RP_W+1)'(REPORT_DEPTH)) begin
        rbusy_r <= 1'b0;
        if (!rfound_r && rfree_ok_r) rep_r[rfree_r] <= rcode_r;
      end else begin
        if (rcur == rcode_r) rfound_r <= 1'b1;
        if (rcur == 8'd0 && !rfree_ok_r) begin
          rfree_ok_r <= 1'b1;
          rfree_r    <= rpos_r[RP_W-1:0];
        end
        rpos_r <= rpos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_read) cnt_rd_r <= cnt_mem[idx[CNT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (init_busy)
      cnt_mem[init_r[CNT_W-1:0]] <= '0;
    else if (cmd.msg_hit && !cnt_over && cnt_rd_r != 16'hFFFF)
      cnt_mem[idx[CNT_W-1:0]] <= cnt_rd_r + 16'd1;
    else if (zbusy_r)
      cnt_mem[{word_r, zclr_r}] <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zbusy_r <= 1'b0;
      zclr_r  <= '0;
    end else if (cmd.zero_word) begin
      zbusy_r <= 1'b1;
      zclr_r  <= '0;
    end else if (zbusy_r) begin
      zclr_r  <= zclr_r + 4'd1;
      if (zclr_r == 4'hF) zbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) init_r <= '0;
    else if (init_busy) init_r <= init_r + 1'b1;
  end

  // read data
  logic [7:0] rd_data;
  always_comb begin
    rd_data = '0;
    case (amfs_pkg::sel_t'(sel_r))
      amfs_pkg::SEL_ALARM:
        if (32'(ent_r) < ALARM_LIST_DEPTH) rd_data = alist_r[ent_r[AL_W-1:0]];
      amfs_pkg::SEL_MSG:
        if (32'(ent_r) < MSG_LIST_DEPTH) rd_data = mlist_r[ent_r[ML_W-1:0]];
      amfs_pkg::SEL_REPORT:
        if (32'(ent_r) < REPORT_DEPTH) rd_data = rep_r[ent_r[RP_W-1:0]];
      default: rd_data = '0;
    endcase
  end

  // output stage: one result register; last is set on the held event
  // or a fresh empty result when nothing was sent
  logic out_valid_r, any_r, pend_r;
  amfs_pkg::amfs_out_t out_r;
  amfs_pkg::amfs_out_t pend_ev_r;
  logic [15:0] ev_code;
  assign ev_code = (req_r == amfs_pkg::REQ_MSG) ? msg_base_r + {8'd0, idx}
                                                : alarm_base_r + {8'd0, idx};

  // the newest event is held back until we know whether it is the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.load) any_r <= 1'b0;
      if (cmd.emit_event) begin
        any_r <= 1'b1;
        if (pend_r) out_valid_r <= 1'b1;
        pend_r <= 1'b1;
        out_r  <= pend_ev_r;
        pend_ev_r.event_valid     <= 1'b1;
        pend_ev_r.event_kind      <= (req_r == amfs_pkg::REQ_MSG);
        pend_ev_r.event_code      <= ev_code;
        pend_ev_r.read_data       <= '0;
        pend_ev_r.alarms_active   <= aseen_r | cmd.alarm_op;
        pend_ev_r.messages_active <= mseen_r | cmd.msg_hit;
        pend_ev_r.last            <= 1'b0;
      end else if (cmd.emit_empty) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
        if (pend_r) begin
          out_r      <= pend_ev_r;
          out_r.last <= 1'b1;
        end else begin
          out_r.event_valid <= 1'b0;
          out_r.event_kind  <= 1'b0;
          out_r.event_code  <= '0;
          out_r.read_data   <= (req_r == amfs_pkg::REQ_READ) ? rd_data : 8'd0;
          out_r.last        <= 1'b1;
        end
        out_r.alarms_active   <= aseen_r;
        out_r.messages_active <= mseen_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic in_range;
  always_comb begin
    case (amfs_pkg::req_t'(req_r))
      amfs_pkg::REQ_ALARM: in_range = 32'(word_r) < ALARM_WORDS;
      amfs_pkg::REQ_MSG:   in_range = 32'(word_r) < MSG_WORDS;
      default:             in_range = 1'b0;
    endcase
  end

  always_comb begin
    sts               = '0;
    sts.req_valid     = in_valid && !init_busy && !zbusy_r;
    sts.bits_done     = bit_r[4];
    sts.cur_bit       = flags_r[bit4];
    sts.cnt_over      = cnt_over;
    sts.report_busy   = rbusy_r;
    sts.out_busy      = out_valid_r && !out_ready;
    sts.any_emitted   = any_r;
    sts.word_in_range = in_range;
    sts.req_type      = amfs_pkg::req_t'(req_r);
    sts.flags_zero    = flags_r == 16'd0;
  end

endmodule

>>> rtl/core/amfs_checker.sv
// ----------------------------------------------------------------------------
// amfs_checker
// Port-level checks of the scanner, bound to the top level.
// ----------------------------------------------------------------------------
module amfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_event_valid,
  input logic        out_event_kind,
  input logic [15:0] out_event_code,
  input logic [7:0]  out_read_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_code))
    else $error("result dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_valid |-> !out_event_kind && out_event_code == 16'd0)
    else $error("empty result carries event fields");

  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_valid |-> out_read_data == 8'd0)
    else $error("event result carries read data");

endmodule

bind alarm_message_flag_scanner amfs_checker u_amfs_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_event_valid(out_ch.event_valid), .out_event_kind(out_ch.event_kind),
  .out_event_code(out_ch.event_code), .out_read_data(out_ch.read_data)
);

>>> dv/amfs_sb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amfs_sb
// Scanner predictor and result queue: it keeps its own copy of the lists,
// the persistence counters and the registers, and checks each result beat.
// ----------------------------------------------------------------------------
class amfs_sb;
  logic [15:0] delay_r, alarm_base_r, msg_base_r;
  logic [7:0]  alarm_disp [10];
  logic [7:0]  msg_disp [4];
  logic [7:0]  report [16];
  logic [15:0] persist [256];
  bit          alarm_seen, msg_seen;
  amfs_pkg::amfs_out_t pending [$];
  int          errors;

  function new();
    delay_r = 0; alarm_base_r = 0; msg_base_r = 0;
    foreach (alarm_disp[i]) alarm_disp[i] = 0;
    foreach (msg_disp[i]) msg_disp[i] = 0;
    foreach (report[i]) report[i] = 0;
    foreach (persist[i]) persist[i] = 0;
    alarm_seen = 0; msg_seen = 0; errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    if (idx == amfs_pkg::CFG_MSG_DELAY) delay_r = val;
    else if (idx == amfs_pkg::CFG_ALARM_BASE) alarm_base_r = val;
    else if (idx == amfs_pkg::CFG_MSG_BASE) msg_base_r = val;
  endfunction

  function void push_event(bit kind, logic [15:0] code, logic [7:0] data, bit ev);
    amfs_pkg::amfs_out_t r;
    r.event_valid = ev; r.event_kind = kind; r.event_code = code;
    r.read_data = data; r.alarms_active = alarm_seen;
    r.messages_active = msg_seen; r.last = 0;
    pending.push_back(r);
  endfunction

  function void add_report(logic [7:0] code);
    foreach (report[i]) if (report[i] == code) return;
    foreach (report[i]) if (report[i] == 0) begin
      report[i] = code;
      return;
    end
  endfunction

  // note an accepted input beat and queue what it should produce
  function void note_input(logic [1:0] req, logic [3:0] word, logic [15:0] flags,
                           bit start, bit clr, logic [1:0] sel, logic [3:0] ent);
    int n;
    logic [7:0] idx, data;
    n = pending.size();
    if (start) begin
      foreach (alarm_disp[i]) alarm_disp[i] = 0;
      foreach (msg_disp[i]) msg_disp[i] = 0;
      alarm_seen = 0; msg_seen = 0;
    end
    if (clr) foreach (report[i]) report[i] = 0;
    if (req == amfs_pkg::REQ_ALARM) begin
      for (int b = 0; b < 16; b++) if (flags[b]) begin
        idx = {word, b[3:0]};
        alarm_seen = 1;
        for (int i = 9; i > 0; i--) alarm_disp[i] = alarm_disp[i-1];
        alarm_disp[0] = idx;
        add_report(idx);
        push_event(0, alarm_base_r + idx, 0, 1);
      end
    end else if (req == amfs_pkg::REQ_MSG) begin
      if (flags == 0) begin
        for (int b = 0; b < 16; b++) persist[{word, b[3:0]}] = 0;
      end else begin
        for (int b = 0; b < 16; b++) if (flags[b]) begin
          idx = {word, b[3:0]};
          msg_seen = 1;
          if (persist[idx] > delay_r) begin
            for (int i = 3; i > 0; i--) msg_disp[i] = msg_disp[i-1];
            msg_disp[0] = idx;
            push_event(1, msg_base_r + idx, 0, 1);
          end else if (persist[idx] != 16'hFFFF) begin
            persist[idx]++;
          end
        end
      end
    end else if (req == amfs_pkg::REQ_READ) begin
      data = 0;
      if (sel == amfs_pkg::SEL_ALARM && ent < 10) data = alarm_disp[ent];
      else if (sel == amfs_pkg::SEL_MSG && ent < 4) data = msg_disp[ent];
      else if (sel == amfs_pkg::SEL_REPORT) data = report[ent];
      push_event(0, 0, data, 0);
    end
    if (pending.size() == n) push_event(0, 0, 0, 0);
    pending[pending.size()-1].last = 1;
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task check_result(amfs_pkg::amfs_out_t got);
    amfs_pkg::amfs_out_t w;
    if (pending.size() == 0) begin
      report_mismatch("unexpected result beat", 1, 0);
      return;
    end
    w = pending.pop_front();
    if (got.event_valid !== w.event_valid)
      report_mismatch("event_valid", got.event_valid, w.event_valid);
    if (got.event_kind !== w.event_kind)
      report_mismatch("event_kind", got.event_kind, w.event_kind);
    if (got.event_code !== w.event_code)
      report_mismatch("event_code", got.event_code, w.event_code);
    if (got.read_data !== w.read_data)
      report_mismatch("read_data", got.read_data, w.read_data);
    if (got.alarms_active !== w.alarms_active)
      report_mismatch("alarms_active", got.alarms_active, w.alarms_active);
    if (got.messages_active !== w.messages_active)
      report_mismatch("messages_active", got.messages_active, w.messages_active);
    if (got.last !== w.last)
      report_mismatch("last", got.last, w.last);
  endtask
endclass

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives flag words, reads and register writes into the scanner under random
// idling on both channels, and checks every result beat against the predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT = 20000;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [amfs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [amfs_pkg::CFG_DATA_W-1:0] cfg_data;
  amfs_in_if  in_ch ();
  amfs_out_if out_ch ();
  amfs_sb sb;
  bit quiet_phase, finished;
  int idle_cycles;

  alarm_message_flag_scanner DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // result side: random ready bursts, check on accept
  initial begin
    int n;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        n = $urandom_range(1, 11);
        repeat (n) @(negedge clk);
      end
      out_ch.ready <= 1;
    end
  end

  always @(posedge clk) begin
    amfs_pkg::amfs_out_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.event_valid = out_ch.event_valid; r.event_kind = out_ch.event_kind;
      r.event_code = out_ch.event_code; r.read_data = out_ch.read_data;
      r.alarms_active = out_ch.alarms_active;
      r.messages_active = out_ch.messages_active; r.last = out_ch.last;
      sb.check_result(r);
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !finished) begin
      $display("FAILURE");
      $finish;
    end
  end

  // valid stays high into the next beat unless an idle burst comes first
  task send_beat(logic [1:0] req, logic [3:0] word, logic [15:0] flags,
                 bit start, bit clr, logic [1:0] sel, logic [3:0] ent);
    int n;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 11);
      in_ch.valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1; in_ch.req_type <= req; in_ch.word_index <= word;
    in_ch.flag_bits <= flags; in_ch.scan_start <= start;
    in_ch.clear_report_list <= clr; in_ch.list_select <= sel;
    in_ch.entry_index <= ent;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(req, word, flags, start, clr, sel, ent);
    @(negedge clk);
  endtask

  task drain;
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    @(negedge clk);
    sb.write_reg(idx, val);
  endtask

  // random item with random content; mostly alarms and messages, with reads and type 3 items
  task random_beat();
    int k;
    logic [15:0] f;
    k = $urandom_range(0, 9);
    f = ($urandom_range(0, 3) == 0) ? 16'($urandom) : (16'h1 << $urandom_range(0, 15));
    if ($urandom_range(0, 5) == 0) f = 16'd0;
    if (k < 4)
      send_beat(amfs_pkg::REQ_ALARM, 4'($urandom), f, $urandom_range(0, 7) == 0,
                $urandom_range(0, 15) == 0, 2'($urandom), 4'($urandom));
    else if (k < 7)
      send_beat(amfs_pkg::REQ_MSG, 4'($urandom_range(0, 3)), f,
                $urandom_range(0, 7) == 0, 1'b0, 2'($urandom), 4'($urandom));
    else if (k < 9)
      send_beat(amfs_pkg::REQ_READ, 4'($urandom), 16'($urandom), 1'b0, 1'b0,
                2'($urandom), 4'($urandom));
    else
      send_beat(amfs_pkg::REQ_NONE, 4'($urandom), 16'($urandom), 1'($urandom),
                1'($urandom), 2'($urandom), 4'($urandom));
  endtask

  initial begin
    sb = new();
    idle_cycles = 0; finished = 0; quiet_phase = 0;
    rst_n = 0; cfg_wr_en = 0; cfg_index = 0; cfg_data = 0;
    in_ch.valid = 0; in_ch.req_type = amfs_pkg::REQ_ALARM; in_ch.word_index = 0;
    in_ch.flag_bits = 0; in_ch.scan_start = 0; in_ch.clear_report_list = 0;
    in_ch.list_select = amfs_pkg::SEL_ALARM; in_ch.entry_index = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: delay 0, a small alarm base and a message base near the top
    write_reg(amfs_pkg::CFG_MSG_DELAY, 16'd0);
    write_reg(amfs_pkg::CFG_ALARM_BASE, 16'h0100);
    write_reg(amfs_pkg::CFG_MSG_BASE, 16'hFFF0);
    // index zero alarm
    send_beat(amfs_pkg::REQ_ALARM, 4'd0, 16'h0001, 1'b1, 1'b1, amfs_pkg::SEL_ALARM, 4'd0);
    send_beat(amfs_pkg::REQ_ALARM, 4'd15, 16'hFFFF, 1'b0, 1'b0, amfs_pkg::SEL_ALARM, 4'd0);
    send_beat(amfs_pkg::REQ_ALARM, 4'd3, 16'h0000, 1'b0, 1'b0, amfs_pkg::SEL_ALARM, 4'd0);
    // alarms while the report list is full
    send_beat(amfs_pkg::REQ_ALARM, 4'd1, 16'hFFFF, 1'b0, 1'b0, amfs_pkg::SEL_ALARM, 4'd0);
    send_beat(amfs_pkg::REQ_ALARM, 4'd2, 16'h8001, 1'b0, 1'b0, amfs_pkg::SEL_ALARM, 4'd0);
    for (int e = 0; e < 16; e += 3)
      send_beat(amfs_pkg::REQ_READ, 4'd0, 16'd0, 1'b0, 1'b0, amfs_pkg::SEL_REPORT, 4'(e));
    send_beat(amfs_pkg::REQ_READ, 4'd0, 16'd0, 1'b0, 1'b0, amfs_pkg::SEL_ALARM, 4'd9);
    send_beat(amfs_pkg::REQ_READ, 4'd0, 16'd0, 1'b0, 1'b0, amfs_pkg::SEL_ALARM, 4'd10);
    send_beat(amfs_pkg::REQ_READ, 4'd0, 16'd0, 1'b0, 1'b0, amfs_pkg::SEL_NONE, 4'd0);
    send_beat(amfs_pkg::REQ_MSG, 4'd15, 16'hFFFF, 1'b0, 1'b0, amfs_pkg::SEL_MSG, 4'd0);
    send_beat(amfs_pkg::REQ_MSG, 4'd15, 16'hFFFF, 1'b0, 1'b0, amfs_pkg::SEL_MSG, 4'd0);
    send_beat(amfs_pkg::REQ_MSG, 4'd15, 16'h0000, 1'b0, 1'b0, amfs_pkg::SEL_MSG, 4'd0);
    send_beat(amfs_pkg::REQ_MSG, 4'd15, 16'h8000, 1'b0, 1'b0, amfs_pkg::SEL_MSG, 4'd0);
    send_beat(amfs_pkg::REQ_READ, 4'd0, 16'd0, 1'b0, 1'b0, amfs_pkg::SEL_MSG, 4'd3);
    send_beat(amfs_pkg::REQ_READ, 4'd0, 16'd0, 1'b0, 1'b0, amfs_pkg::SEL_MSG, 4'd4);
    send_beat(amfs_pkg::REQ_NONE, 4'd0, 16'hFFFF, 1'b1, 1'b1, amfs_pkg::SEL_NONE, 4'd15);
    drain();

    // delay at ceiling: messages never report
    write_reg(amfs_pkg::CFG_MSG_DELAY, 16'hFFFF);
    write_reg(amfs_pkg::CFG_ALARM_BASE, 16'hFFFF);
    write_reg(amfs_pkg::CFG_MSG_BASE, 16'd0);
    for (int i = 0; i < 40; i++) random_beat();
    drain();  // sender pauses until all results are back

    write_reg(amfs_pkg::CFG_MSG_DELAY, 16'($urandom_range(0, 3)));
    write_reg(amfs_pkg::CFG_ALARM_BASE, 16'($urandom));
    write_reg(amfs_pkg::CFG_MSG_BASE, 16'($urandom));
    for (int i = 0; i < 70; i++) random_beat();
    drain();

    write_reg(amfs_pkg::CFG_MSG_DELAY, 16'd1);
    write_reg(amfs_pkg::CFG_ALARM_BASE, 16'($urandom));
    write_reg(amfs_pkg::CFG_MSG_BASE, 16'hFFFF);
    quiet_phase = 1;
    for (int i = 0; i < 40; i++) random_beat();
    drain();
    finished = 1;
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

>>> files.f
rtl/core/amfs_pkg.sv
rtl/core/amfs_if.sv
rtl/core/amfs_ctrl.sv
rtl/core/amfs_dpath.sv
rtl/core/alarm_message_flag_scanner.sv
rtl/core/amfs_checker.sv
dv/amfs_sb.sv
dv/tb_top.sv
